### rtl/core/mer_pkg.sv
package mer_pkg;

    // Field widths
    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 12;

    // Derived datapath widths
    localparam int SQ_W   = 2 * RADIUS_BITS;           // radius squared
    localparam int X_W    = RADIUS_BITS + 1;           // point x, unsigned
    localparam int Y_W    = RADIUS_BITS + 1;           // point y, signed (reaches -1)
    localparam int TX_W   = X_W + 1;                   // 2x+1
    localparam int MA_W   = 2 * TX_W;                  // multiplier operand a
    localparam int MB_W   = SQ_W;                      // multiplier operand b
    localparam int MP_W   = MA_W + MB_W;               // multiplier product
    localparam int STEP_W = SQ_W + X_W + 3;            // step_dx / step_dy, signed
    localparam int D_W    = MP_W + 4;                  // decision, scaled by four
    localparam int PIX_W  = COORD_BITS + 1;            // output pixel coordinate

    // Stream packing
    localparam int IN_FIELDS_W  = 2 * RADIUS_BITS + 2 * COORD_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * PIX_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes carried on s_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Symmetric corners, bit 0 negates x, bit 1 negates y
    localparam logic [1:0] CORNER_PP = 2'd0;
    localparam logic [1:0] CORNER_MP = 2'd1;
    localparam logic [1:0] CORNER_PM = 2'd2;
    localparam logic [1:0] CORNER_MM = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_INIT_MUL,
        ST_INIT_SET,
        ST_RC_TX,
        ST_RC_TXR,
        ST_RC_YM,
        ST_RC_YMR,
        ST_RC_RR,
        ST_RC_SET,
        ST_EMIT0,
        ST_EMIT1,
        ST_EMIT2,
        ST_EMIT3,
        ST_UPD_POS,
        ST_UPD_DEC
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SQ_RX,
        CMD_SQ_RY,
        CMD_INIT_MUL,
        CMD_INIT_SET,
        CMD_RC_TX,
        CMD_RC_TXR,
        CMD_RC_YM,
        CMD_RC_YMR,
        CMD_RC_RR,
        CMD_RC_SET,
        CMD_EMIT,
        CMD_UPD_POS,
        CMD_UPD_DEC
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] corner;
    } dp_cmd_t;

    typedef struct packed {
        logic need_change;   // region 1 and step_dx >= step_dy
        logic last_group;    // region 2 and y == 0
        logic out_free;      // output register can take a pixel this cycle
    } dp_status_t;

endpackage

### rtl/core/mer_datapath.sv
module mer_datapath
    import mer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    // Ellipse state
    logic        [RADIUS_BITS-1:0] rx_reg;
    logic        [SQ_W-1:0]        rx2_reg;
    logic        [SQ_W-1:0]        ry2_reg;
    logic signed [COORD_BITS-1:0]  cx_reg;
    logic signed [COORD_BITS-1:0]  cy_reg;
    logic        [X_W-1:0]         x_reg;
    logic signed [Y_W-1:0]         y_reg;
    logic signed [STEP_W-1:0]      sdx_reg;
    logic signed [STEP_W-1:0]      sdy_reg;
    logic signed [D_W-1:0]         d_reg;
    logic signed [D_W-1:0]         acc_reg;
    logic        [MP_W-1:0]        mul_reg;
    logic                          region2_reg;

    // Output register
    logic                          out_valid_reg;
    logic [OUT_DATA_W-1:0]         out_data_reg;
    logic                          out_last_reg;
    logic                          out_done_reg;

    // Shared multiplier operands
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic [MP_W-1:0] mul_p;

    logic [TX_W-1:0]       tx1;
    logic signed [Y_W-1:0] ym1;
    logic [Y_W-1:0]        ym1_mag;

    logic signed [D_W-1:0]    mul_d;
    logic signed [D_W-1:0]    rx2_d;
    logic signed [D_W-1:0]    ry2_d;
    logic signed [D_W-1:0]    sdx_d;
    logic signed [D_W-1:0]    sdy_d;
    logic signed [D_W-1:0]    term;
    logic signed [STEP_W-1:0] mul_s;
    logic signed [STEP_W-1:0] two_rx2;
    logic signed [STEP_W-1:0] two_ry2;
    logic                     d_neg;
    logic                     d_pos;

    logic [PIX_W-1:0] cx_pix;
    logic [PIX_W-1:0] cy_pix;
    logic [PIX_W-1:0] x_pix;
    logic [PIX_W-1:0] y_pix;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             out_free;

    // Region-change operands: 2x+1 and |y-1|
    assign tx1     = {x_reg, 1'b1};
    assign ym1     = y_reg - Y_W'(1);
    assign ym1_mag = ym1[Y_W-1] ? Y_W'(-ym1) : Y_W'(ym1);

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.cmd)
            CMD_SQ_RX:
            begin
                mul_a = MA_W'(rx_reg);
                mul_b = MB_W'(rx_reg);
            end
            CMD_SQ_RY:
            begin
                mul_a = MA_W'(y_reg[RADIUS_BITS-1:0]);
                mul_b = MB_W'(y_reg[RADIUS_BITS-1:0]);
            end
            CMD_INIT_MUL:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = MB_W'(y_reg[RADIUS_BITS-1:0]);
            end
            CMD_RC_TX:
            begin
                mul_a = MA_W'(tx1);
                mul_b = MB_W'(tx1);
            end
            CMD_RC_TXR:
            begin
                mul_a = mul_reg[MA_W-1:0];
                mul_b = ry2_reg;
            end
            CMD_RC_YM:
            begin
                mul_a = MA_W'(ym1_mag);
                mul_b = MB_W'(ym1_mag);
            end
            CMD_RC_YMR:
            begin
                mul_a = mul_reg[MA_W-1:0];
                mul_b = rx2_reg;
            end
            CMD_RC_RR:
            begin
                mul_a = MA_W'(ry2_reg);
                mul_b = rx2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

    // Signed views for the decision arithmetic
    assign mul_d   = $signed({{(D_W-MP_W){1'b0}}, mul_reg});
    assign mul_s   = $signed(mul_reg[STEP_W-1:0]);
    assign rx2_d   = $signed({{(D_W-SQ_W){1'b0}}, rx2_reg});
    assign ry2_d   = $signed({{(D_W-SQ_W){1'b0}}, ry2_reg});
    assign sdx_d   = $signed({{(D_W-STEP_W){sdx_reg[STEP_W-1]}}, sdx_reg});
    assign sdy_d   = $signed({{(D_W-STEP_W){sdy_reg[STEP_W-1]}}, sdy_reg});
    assign two_rx2 = $signed({{(STEP_W-SQ_W-1){1'b0}}, rx2_reg, 1'b0});
    assign two_ry2 = $signed({{(STEP_W-SQ_W-1){1'b0}}, ry2_reg, 1'b0});
    assign d_neg   = d_reg[D_W-1];
    assign d_pos   = !d_neg && (d_reg != '0);

    // Decision increment, taken with the already advanced step values
    always_comb
    begin
        if (!region2_reg)
        begin
            term = d_neg ? (sdx_d + ry2_d) : (sdx_d - sdy_d + ry2_d);
        end
        else
        begin
            term = d_pos ? (rx2_d - sdy_d) : (rx2_d + sdx_d - sdy_d);
        end
    end

    // Pixel of the selected corner, wrapped to the output width
    assign cx_pix = PIX_W'(cx_reg);
    assign cy_pix = PIX_W'(cy_reg);
    assign x_pix  = PIX_W'(x_reg);
    assign y_pix  = PIX_W'(y_reg);
    assign px     = cmd.corner[0] ? (cx_pix - x_pix) : (cx_pix + x_pix);
    assign py     = cmd.corner[1] ? (cy_pix - y_pix) : (cy_pix + y_pix);

    assign out_free = !out_valid_reg || m_tready;

    // Status toward the controller
    assign status.need_change = !region2_reg && !(sdx_reg < sdy_reg);
    assign status.last_group  = region2_reg && (y_reg == '0);
    assign status.out_free    = out_free;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region2_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cmd == CMD_LOAD)
            begin
                region2_reg <= 1'b0;
            end
            else if (cmd.cmd == CMD_RC_SET)
            begin
                region2_reg <= 1'b1;
            end

            if (cmd.cmd == CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_p;
        case (cmd.cmd)
            CMD_LOAD:
            begin
                rx_reg  <= s_tdata[RADIUS_BITS-1:0];
                y_reg   <= $signed({1'b0, s_tdata[2*RADIUS_BITS-1:RADIUS_BITS]});
                cx_reg  <= $signed(s_tdata[2*RADIUS_BITS+COORD_BITS-1:2*RADIUS_BITS]);
                cy_reg  <= $signed(s_tdata[IN_FIELDS_W-1:2*RADIUS_BITS+COORD_BITS]);
                x_reg   <= '0;
                sdx_reg <= '0;
            end
            CMD_SQ_RY:
            begin
                rx2_reg <= mul_reg[SQ_W-1:0];
            end
            CMD_INIT_MUL:
            begin
                ry2_reg <= mul_reg[SQ_W-1:0];
            end
            CMD_INIT_SET:
            begin
                // step_dy = 2*rx^2*ry, d = 4*ry^2 - 4*rx^2*ry + rx^2
                sdy_reg <= mul_s <<< 1;
                d_reg   <= (ry2_d <<< 2) - (mul_d <<< 2) + rx2_d;
            end
            CMD_RC_YM:
            begin
                acc_reg <= mul_d;
            end
            CMD_RC_RR:
            begin
                acc_reg <= acc_reg + (mul_d <<< 2);
            end
            CMD_RC_SET:
            begin
                d_reg <= acc_reg - (mul_d <<< 2);
            end
            CMD_EMIT:
            begin
                out_data_reg <= OUT_DATA_W'({py, px});
                out_last_reg <= (cmd.corner == CORNER_MM);
                out_done_reg <= status.last_group;
            end
            CMD_UPD_POS:
            begin
                if (!region2_reg)
                begin
                    x_reg   <= x_reg + X_W'(1);
                    sdx_reg <= sdx_reg + two_ry2;
                    if (!d_neg)
                    begin
                        y_reg   <= y_reg - Y_W'(1);
                        sdy_reg <= sdy_reg - two_rx2;
                    end
                end
                else
                begin
                    y_reg   <= y_reg - Y_W'(1);
                    sdy_reg <= sdy_reg - two_rx2;
                    if (!d_pos)
                    begin
                        x_reg   <= x_reg + X_W'(1);
                        sdx_reg <= sdx_reg + two_ry2;
                    end
                end
            end
            CMD_UPD_DEC:
            begin
                d_reg <= d_reg + (term <<< 2);
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

### rtl/core/mer_ctrl.sv
module mer_ctrl
    import mer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   active_reg;
    logic   active_next;
    logic   start_in;

    assign start_in = s_tvalid && (s_tuser == OP_START);

    // State and active flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_in)
                begin
                    state_next = ST_SQ_RX;
                end
                else if (s_tvalid && active_reg)
                begin
                    state_next = status.need_change ? ST_RC_TX : ST_EMIT0;
                end
            end
            ST_SQ_RX:    state_next = ST_SQ_RY;
            ST_SQ_RY:    state_next = ST_INIT_MUL;
            ST_INIT_MUL: state_next = ST_INIT_SET;
            ST_INIT_SET: state_next = ST_IDLE;
            ST_RC_TX:    state_next = ST_RC_TXR;
            ST_RC_TXR:   state_next = ST_RC_YM;
            ST_RC_YM:    state_next = ST_RC_YMR;
            ST_RC_YMR:   state_next = ST_RC_RR;
            ST_RC_RR:    state_next = ST_RC_SET;
            ST_RC_SET:   state_next = ST_EMIT0;
            ST_EMIT0:    state_next = status.out_free ? ST_EMIT1 : ST_EMIT0;
            ST_EMIT1:    state_next = status.out_free ? ST_EMIT2 : ST_EMIT1;
            ST_EMIT2:    state_next = status.out_free ? ST_EMIT3 : ST_EMIT2;
            ST_EMIT3:    state_next = status.out_free ? ST_UPD_POS : ST_EMIT3;
            ST_UPD_POS:  state_next = ST_UPD_DEC;
            ST_UPD_DEC:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake and datapath commands
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.cmd     = CMD_NONE;
        cmd.corner  = CORNER_PP;
        active_next = active_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (start_in)
                begin
                    cmd.cmd     = CMD_LOAD;
                    active_next = 1'b1;
                end
            end
            ST_SQ_RX:    cmd.cmd = CMD_SQ_RX;
            ST_SQ_RY:    cmd.cmd = CMD_SQ_RY;
            ST_INIT_MUL: cmd.cmd = CMD_INIT_MUL;
            ST_INIT_SET: cmd.cmd = CMD_INIT_SET;
            ST_RC_TX:    cmd.cmd = CMD_RC_TX;
            ST_RC_TXR:   cmd.cmd = CMD_RC_TXR;
            ST_RC_YM:    cmd.cmd = CMD_RC_YM;
            ST_RC_YMR:   cmd.cmd = CMD_RC_YMR;
            ST_RC_RR:    cmd.cmd = CMD_RC_RR;
            ST_RC_SET:   cmd.cmd = CMD_RC_SET;
            ST_EMIT0:
            begin
                cmd.cmd    = status.out_free ? CMD_EMIT : CMD_NONE;
                cmd.corner = CORNER_PP;
            end
            ST_EMIT1:
            begin
                cmd.cmd    = status.out_free ? CMD_EMIT : CMD_NONE;
                cmd.corner = CORNER_MP;
            end
            ST_EMIT2:
            begin
                cmd.cmd    = status.out_free ? CMD_EMIT : CMD_NONE;
                cmd.corner = CORNER_PM;
            end
            ST_EMIT3:
            begin
                cmd.cmd    = status.out_free ? CMD_EMIT : CMD_NONE;
                cmd.corner = CORNER_MM;
            end
            ST_UPD_POS:
            begin
                cmd.cmd = CMD_UPD_POS;
                // final group has been loaded into the output register: the ellipse is no longer active
                if (status.last_group)
                begin
                    active_next = 1'b0;
                end
            end
            ST_UPD_DEC:  cmd.cmd = CMD_UPD_DEC;
            default:
            begin
                cmd.cmd = CMD_NONE;
            end
        endcase
    end

endmodule

### rtl/core/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer. A start transfer (s_tuser = 0) loads the two radii and the
// centre and sets up the decision value, producing no pixel. Each step transfer (s_tuser = 1)
// then yields four pixels, (+x,+y), (-x,+y), (+x,-y), (-x,-y) about the centre, the fourth
// with m_tlast, and all four with m_tuser set on the ellipse's final group; a step while no
// ellipse is active is taken and dropped. A step passes through the accept, four pixel loads
// of the output register, the position update and the decision update; the one step where
// the walk moves from region 1 to region 2 first forms that decision value from five products,
// one per cycle on a single shared multiplier. Back-pressure on the master side stretches
// the pixel loads. s_tready is high only between items; a finished pixel may still wait in
// the output register while the next item is taken. Pixel coordinates wrap to 13 bits.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // radius_x, radius_y, centre_x, centre_y, zero pad
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, zero pad
    output logic                  m_tlast,   // group_last
    output logic                  m_tuser    // ellipse_done
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and output register
    mer_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/core/mer_checker.sv
module mer_checker
    import mer_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser
);

    // A stalled pixel holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled pixel changed");

    // Setup after a start keeps the input closed
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_START) |=> !s_tready)
        else $error("input open right after a start transfer");

    // No new item while a group is still going out
    a_group_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of a group");

    // Pixels of one group follow back to back with the same final flag
    a_group_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser)))
        else $error("group broken or final flag changed within a group");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);
